>>> src/par_pkg.sv
// ----------------------------------------------------------------------------
// par_pkg
// Shared types, constants and the sine table builder for the point rotator.
// ----------------------------------------------------------------------------
package par_pkg;

    localparam int COORD_BITS_DEF     = 24;
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int TRIG_FRAC_MAX      = 24;
    localparam int ADDR_BITS          = 3;
    localparam int DATA_BITS          = 32;
    localparam int ANGLE_BITS         = 9;
    localparam int RATIO_BITS         = 7;
    localparam int ROM_LAST           = 90;

    localparam logic REG_AXIS  = 1'b0;
    localparam logic REG_ANGLE = 1'b1;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    typedef struct packed {
        t_axis                  axis;
        logic [ANGLE_BITS-1:0]  angle;
    } t_cfg;

    typedef logic [ROM_LAST:0][TRIG_FRAC_MAX-1:0] t_sin_rom;

    function automatic longint unsigned taylor_mul(input longint unsigned term,
                                                   input longint unsigned x2);
        return (term * x2 + (64'd1 << 29)) >> 30;
    endfunction

    // quarter-wave sine, entry d is sin(d deg) in unsigned Q0.frac
    function automatic t_sin_rom build_sin_rom(input int frac);
        t_sin_rom           rom;
        longint unsigned    x;
        longint unsigned    x2;
        longint unsigned    term;
        longint             sum;
        longint             v;
        longint             cap;
        rom = '0;
        cap = (64'sd1 <<< frac) - 64'sd1;
        for (int d = 0; d <= ROM_LAST; d++) begin
            x    = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = longint'(x);
            term = taylor_mul(term, x2) / 64'd6;
            sum  = sum - longint'(term);
            term = taylor_mul(term, x2) / 64'd20;
            sum  = sum + longint'(term);
            term = taylor_mul(term, x2) / 64'd42;
            sum  = sum - longint'(term);
            term = taylor_mul(term, x2) / 64'd72;
            sum  = sum + longint'(term);
            term = taylor_mul(term, x2) / 64'd110;
            sum  = sum - longint'(term);
            term = taylor_mul(term, x2) / 64'd156;
            sum  = sum + longint'(term);
            term = taylor_mul(term, x2) / 64'd210;
            sum  = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
            if (v > cap) begin
                v = cap;
            end
            rom[d] = TRIG_FRAC_MAX'(v);
        end
        return rom;
    endfunction

endpackage

>>> src/par_apb_regs.sv
// ----------------------------------------------------------------------------
// par_apb_regs
// APB register file holding the rotation axis and angle.
// ----------------------------------------------------------------------------
module par_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [par_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [par_pkg::DATA_BITS-1:0]      pwdata,
    output logic [par_pkg::DATA_BITS-1:0]      prdata,
    output par_pkg::t_cfg                      o_cfg
);
    import par_pkg::*;

    t_cfg r_cfg;
    logic w_write;
    logic w_sel;

    assign w_write = psel & penable & pwrite;
    assign w_sel   = paddr[ADDR_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis  <= AXIS_X;
            r_cfg.angle <= '0;
        end else if (w_write) begin
            unique case (w_sel)
                REG_AXIS:  r_cfg.axis  <= t_axis'(pwdata[1:0]);
                REG_ANGLE: r_cfg.angle <= pwdata[ANGLE_BITS-1:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_AXIS:  prdata = DATA_BITS'(r_cfg.axis);
            REG_ANGLE: prdata = DATA_BITS'(r_cfg.angle);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/point_axis_rotation.sv
// ----------------------------------------------------------------------------
// point_axis_rotation
// Rotates a 3D fixed-point point about the x, y or z axis by a whole-degree angle.
// ----------------------------------------------------------------------------
// One point enters per clock while o_stall is low. Its result passes through
// angle reduction, sine table lookup, a row of four coefficient multipliers,
// then sum, round and saturate into the output register. A stall on the output
// holds every full stage; bubbles still move.
module point_axis_rotation #(
    parameter int COORD_BITS     = par_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = par_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_BITS-1:0]       i_coord_x,
    input  logic signed [COORD_BITS-1:0]       i_coord_y,
    input  logic signed [COORD_BITS-1:0]       i_coord_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [COORD_BITS-1:0]       o_rot_x,
    output logic signed [COORD_BITS-1:0]       o_rot_y,
    output logic signed [COORD_BITS-1:0]       o_rot_z,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [par_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [par_pkg::DATA_BITS-1:0]      pwdata,
    output logic [par_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);
    import par_pkg::*;

    localparam int CW = TRIG_FRAC_BITS + 2;
    localparam int PW = COORD_BITS + CW;
    localparam int SW = PW + 2;
    localparam t_sin_rom SIN_ROM = build_sin_rom(TRIG_FRAC_BITS);
    localparam logic signed [CW-1:0] COEF_ONE = CW'(64'd1 << TRIG_FRAC_BITS);
    localparam logic signed [SW-1:0] RND      = SW'(64'd1 << (TRIG_FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SAT_MAX  = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN  = -SAT_MAX - SW'(1);

    t_cfg w_cfg;

    par_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    assign pready = 1'b1;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    assign w_en4   = !r_v4 || !i_stall;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: angle reduction to quadrant and remainder
    logic [ANGLE_BITS-1:0] w_ang;
    logic [1:0]            n_quad;
    logic [RATIO_BITS-1:0] n_rem;
    logic [1:0]            r_quad;
    logic [RATIO_BITS-1:0] r_rem;
    t_axis                 r_axis1;
    logic signed [COORD_BITS-1:0] r_x1, r_y1, r_z1;

    assign w_ang = (w_cfg.angle >= ANGLE_BITS'(360)) ?
                   ANGLE_BITS'(w_cfg.angle - ANGLE_BITS'(360)) : w_cfg.angle;

    always_comb begin
        priority if (w_ang >= ANGLE_BITS'(270)) begin
            n_quad = 2'd3;
            n_rem  = RATIO_BITS'(w_ang - ANGLE_BITS'(270));
        end else if (w_ang >= ANGLE_BITS'(180)) begin
            n_quad = 2'd2;
            n_rem  = RATIO_BITS'(w_ang - ANGLE_BITS'(180));
        end else if (w_ang >= ANGLE_BITS'(90)) begin
            n_quad = 2'd1;
            n_rem  = RATIO_BITS'(w_ang - ANGLE_BITS'(90));
        end else begin
            n_quad = 2'd0;
            n_rem  = RATIO_BITS'(w_ang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_quad  <= n_quad;
            r_rem   <= n_rem;
            r_axis1 <= w_cfg.axis;
            r_x1    <= i_coord_x;
            r_y1    <= i_coord_y;
            r_z1    <= i_coord_z;
        end
    end

    // stage 2: table lookup, sign by quadrant, operand routing by axis
    logic signed [CW-1:0] w_a, w_b;
    logic signed [CW-1:0] n_sin, n_cos, r_sin, r_cos;
    logic signed [COORD_BITS-1:0] n_u, n_v, n_w, r_u, r_v, r_w;
    t_axis r_axis2;

    assign w_a = CW'(SIN_ROM[r_rem][TRIG_FRAC_BITS-1:0]);
    assign w_b = CW'(SIN_ROM[RATIO_BITS'(ROM_LAST - int'(r_rem))][TRIG_FRAC_BITS-1:0]);

    always_comb begin
        unique case (r_quad)
            2'd0:    begin n_sin = w_a;  n_cos = w_b;  end
            2'd1:    begin n_sin = w_b;  n_cos = -w_a; end
            2'd2:    begin n_sin = -w_a; n_cos = -w_b; end
            default: begin n_sin = -w_b; n_cos = w_a;  end
        endcase
        unique case (r_axis1)
            AXIS_X: begin n_u = r_y1; n_v = r_z1; n_w = r_x1; end
            AXIS_Y: begin n_u = r_x1; n_v = r_z1; n_w = r_y1; end
            AXIS_Z: begin n_u = r_x1; n_v = r_y1; n_w = r_z1; end
            default: begin
                n_u   = r_x1;
                n_v   = r_y1;
                n_w   = r_z1;
                n_sin = '0;
                n_cos = COEF_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_sin   <= n_sin;
            r_cos   <= n_cos;
            r_u     <= n_u;
            r_v     <= n_v;
            r_w     <= n_w;
            r_axis2 <= r_axis1;
        end
    end

    // stage 3: products
    logic signed [PW-1:0] r_cu, r_sv, r_su, r_cv;
    logic signed [COORD_BITS-1:0] r_w3;
    t_axis r_axis3;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_cu    <= PW'(r_cos) * PW'(r_u);
            r_sv    <= PW'(r_sin) * PW'(r_v);
            r_su    <= PW'(r_sin) * PW'(r_u);
            r_cv    <= PW'(r_cos) * PW'(r_v);
            r_w3    <= r_w;
            r_axis3 <= r_axis2;
        end
    end

    // stage 4: sum, round, saturate
    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [SW-1:0] sum
    );
        logic signed [SW-1:0] sh;
        sh = (sum + RND) >>> TRIG_FRAC_BITS;
        if (sh > SAT_MAX) begin
            sh = SAT_MAX;
        end else if (sh < SAT_MIN) begin
            sh = SAT_MIN;
        end
        return sh[COORD_BITS-1:0];
    endfunction

    logic signed [COORD_BITS-1:0] w_p, w_q;
    logic signed [COORD_BITS-1:0] n_rot_x, n_rot_y, n_rot_z;
    logic signed [COORD_BITS-1:0] r_rot_x, r_rot_y, r_rot_z;

    assign w_p = round_sat(SW'(r_cu) - SW'(r_sv));
    assign w_q = round_sat(SW'(r_su) + SW'(r_cv));

    always_comb begin
        unique case (r_axis3)
            AXIS_X:  begin n_rot_x = r_w3; n_rot_y = w_p;  n_rot_z = w_q;  end
            AXIS_Y:  begin n_rot_x = w_p;  n_rot_y = r_w3; n_rot_z = w_q;  end
            default: begin n_rot_x = w_p;  n_rot_y = w_q;  n_rot_z = r_w3; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_rot_x <= n_rot_x;
            r_rot_y <= n_rot_y;
            r_rot_z <= n_rot_z;
        end
    end

    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;
    assign o_rot_z = r_rot_z;

endmodule

>>> src/par_checker.sv
// ----------------------------------------------------------------------------
// par_checker
// Port-level checks for the point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module par_checker #(
    parameter int COORD_BITS = par_pkg::COORD_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [COORD_BITS-1:0]  o_rot_x,
    input logic signed [COORD_BITS-1:0]  o_rot_y,
    input logic signed [COORD_BITS-1:0]  o_rot_z,
    input logic                          pready
);

    // empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("word present right after reset");

    // back-pressure only when the output word is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output word");

    // fixed latency with a free output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("word missing four cycles after acceptance");

    // held word keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rot_x) && $stable(o_rot_y)
                                  && $stable(o_rot_z)))
        else $error("held output word changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind point_axis_rotation par_checker #(.COORD_BITS(COORD_BITS)) u_par_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rot_x (o_rot_x),
    .o_rot_y (o_rot_y),
    .o_rot_z (o_rot_z),
    .pready  (pready)
);

>>> dv/point_axis_rotation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_axis_rotation_test
// Self-checking bench for the point rotator. Points stream in over the
// valid/stall channel under random sender gaps and receiver stalls. Axis and
// angle are programmed over the APB port between phases, while the block is
// idle. Each rotated word is compared field by field with a local fixed-point
// rotation that uses its own quarter-wave sine table.
// ----------------------------------------------------------------------------
module point_axis_rotation_test;
    import par_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int TF            = TRIG_FRAC_BITS_DEF;
    localparam int PHASE_WORDS   = 50;
    localparam int RANDOM_PHASES = 26;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LINES  = 40;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [2:0][CW-1:0]   t_point;

    localparam t_coord MAXC = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord MINC = {1'b1, {(CW-1){1'b0}}};
    localparam logic [ADDR_BITS-1:0] ADDR_AXIS  = ADDR_BITS'(4 * REG_AXIS);
    localparam logic [ADDR_BITS-1:0] ADDR_ANGLE = ADDR_BITS'(4 * REG_ANGLE);

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  o_stall;
    t_coord                i_coord_x = '0;
    t_coord                i_coord_y = '0;
    t_coord                i_coord_z = '0;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    t_coord                o_rot_x;
    t_coord                o_rot_y;
    t_coord                o_rot_z;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_BITS-1:0]  paddr     = '0;
    logic [DATA_BITS-1:0]  pwdata    = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    t_axis                 cfg_axis  = AXIS_X;
    logic [ANGLE_BITS-1:0] cfg_angle = '0;
    longint                sine_tab [0:ROM_LAST];
    t_point                rotated_points [$];
    int                    err_count  = 0;
    bit                    idle_on    = 1'b0;
    int                    stall_left = 0;

    point_axis_rotation dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // sin(deg) in unsigned Q0.TF, taylor series evaluated in Q30
    function automatic longint quarter_sine(input int unsigned deg);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          v;
        x    = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2 + (64'd1 << 29)) >> 30;
            term = term / 64'(2 * n * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (acc + (64'sd1 <<< (29 - TF))) >>> (30 - TF);
        return (v > (64'sd1 <<< TF) - 1) ? (64'sd1 <<< TF) - 1 : v;
    endfunction

    function automatic t_point make_point(input t_coord x, input t_coord y, input t_coord z);
        return {z, y, x};
    endfunction

    function automatic t_point rotate_point(input t_point p);
        longint      coef [3][3];
        longint      acc;
        longint      r;
        longint      s;
        longint      c;
        longint      a;
        longint      b;
        int unsigned ang;
        t_point      q;
        ang = int'(cfg_angle) % 360;
        a   = sine_tab[ang % 90];
        b   = sine_tab[90 - ang % 90];
        case (ang / 90)
            0: begin
                s = a;
                c = b;
            end
            1: begin
                s = b;
                c = -a;
            end
            2: begin
                s = -a;
                c = -b;
            end
            default: begin
                s = -b;
                c = a;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef[i][j] = (i == j) ? (64'sd1 <<< TF) : 64'sd0;
            end
        end
        case (cfg_axis)
            AXIS_X: begin
                coef[1][1] = c;
                coef[1][2] = -s;
                coef[2][1] = s;
                coef[2][2] = c;
            end
            AXIS_Y: begin
                coef[0][0] = c;
                coef[0][2] = -s;
                coef[2][0] = s;
                coef[2][2] = c;
            end
            AXIS_Z: begin
                coef[0][0] = c;
                coef[0][1] = -s;
                coef[1][0] = s;
                coef[1][1] = c;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                acc = acc + coef[i][j] * longint'($signed(p[j]));
            end
            // round half up, then clamp
            r = (acc + (64'sd1 <<< (TF - 1))) >>> TF;
            if (r > longint'(MAXC)) begin
                r = longint'(MAXC);
            end
            if (r < longint'(MINC)) begin
                r = longint'(MINC);
            end
            q[i] = r[CW-1:0];
        end
        return q;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return MAXC;
            1: return MINC;
            2: return t_coord'(int'($urandom_range(0, 8191)) - 4096);
            3: return t_coord'(int'($urandom_range(0, 1)) * 32768 - 16384);
            default: return t_coord'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < REPORT_LINES) begin
            $display("mismatch: %s", what);
        end
        err_count++;
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= int'($urandom_range(0, 18));
            i_stall    <= 1'b1;
        end else begin
            i_stall    <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_point got;
        t_point want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_rot_z, o_rot_y, o_rot_x};
            if (rotated_points.size() == 0) begin
                report_mismatch("output word with no point pending");
            end else begin
                want = rotated_points.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got[i] !== want[i]) begin
                        report_mismatch($sformatf("coordinate %0d: got %0d, expected %0d",
                            i, $signed(got[i]), $signed(want[i])));
                    end
                end
            end
        end
    end

    task automatic send_point(input t_point p);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_coord_x <= p[0];
        i_coord_y <= p[1];
        i_coord_z <= p[2];
        do @(posedge i_clk); while (o_stall);
        rotated_points.push_back(rotate_point(p));
    endtask

    task automatic drain_points();
        i_valid <= 1'b0;
        while (rotated_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // upper bits of each register word carry random junk
    task automatic configure(input t_axis axis, input logic [ANGLE_BITS-1:0] angle);
        logic [DATA_BITS-1:0] axis_word;
        logic [DATA_BITS-1:0] angle_word;
        axis_word                   = $urandom();
        axis_word[1:0]              = axis;
        angle_word                  = $urandom();
        angle_word[ANGLE_BITS-1:0]  = angle;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_AXIS;
        pwdata  <= axis_word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        paddr   <= ADDR_ANGLE;
        pwdata  <= angle_word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_axis  = t_axis'(axis_word[1:0]);
        cfg_angle = angle_word[ANGLE_BITS-1:0];
    endtask

    task automatic random_config();
        logic [ANGLE_BITS-1:0] angle;
        case ($urandom_range(0, 7))
            0: angle = '0;
            1: angle = ANGLE_BITS'(359);
            2: angle = ANGLE_BITS'(360);
            3: angle = '1;
            default: angle = ANGLE_BITS'($urandom_range(0, 511));
        endcase
        configure(t_axis'($urandom_range(0, 3)), angle);
    endtask

    task automatic test_reset_config();
        send_point(make_point(MAXC, MAXC, MAXC));
        send_point(make_point(MINC, MINC, MINC));
        send_point(make_point('0, t_coord'(-1), t_coord'(1)));
        send_point(make_point(t_coord'(16384), t_coord'(-16384), MAXC));
        drain_points();
    endtask

    // quadrant edges, wrap above 360, pass-through axis, rounding ties, clamping
    task automatic test_axis_angles();
        t_axis axes [8]   = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_NONE,
                              AXIS_Z, AXIS_Y, AXIS_X, AXIS_Z};
        int    angles [8] = '{90, 180, 270, 45, 359, 511, 360, 45};
        for (int k = 0; k < 8; k++) begin
            configure(axes[k], ANGLE_BITS'(angles[k]));
            send_point(make_point(MAXC, MAXC, MINC));
            send_point(make_point(MINC, t_coord'(16384), t_coord'(-16384)));
            drain_points();
        end
    endtask

    task automatic test_random_phases();
        idle_on = 1'b1;
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            random_config();
            repeat (PHASE_WORDS) begin
                send_point(make_point(rand_coord(), rand_coord(), rand_coord()));
            end
            drain_points();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        random_config();
        repeat (PHASE_WORDS) begin
            send_point(make_point(rand_coord(), rand_coord(), rand_coord()));
        end
        drain_points();
    endtask

    initial begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : run
        for (int d = 0; d <= ROM_LAST; d++) begin
            sine_tab[d] = quarter_sine(d);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_axis_angles();
        test_random_phases();
        test_back_to_back();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && rotated_points.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/par_pkg.sv
src/par_apb_regs.sv
src/point_axis_rotation.sv
src/par_checker.sv
dv/point_axis_rotation_test.sv
